### hdl/afs_pkg.sv
`default_nettype none
package afs_pkg;

  // Opcodes of an input beat
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_SET_PROG  = 3'd1;
  localparam logic [2:0] OP_SET_FRAME = 3'd2;
  localparam logic [2:0] OP_PAUSE     = 3'd3;
  localparam logic [2:0] OP_RESUME    = 3'd4;
  localparam logic [2:0] OP_RESET     = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] REG_MESH_TOTAL = 3'd0;
  localparam logic [2:0] REG_FIRST      = 3'd1;
  localparam logic [2:0] REG_LAST       = 3'd2;
  localparam logic [2:0] REG_FPS        = 3'd3;
  localparam logic [2:0] REG_SPEED      = 3'd4;
  localparam logic [2:0] REG_LOOP       = 3'd5;

  // Largest mesh frame count; frame indexes are 10 bits wide
  localparam logic [10:0] MAX_FRAMES = 11'd1024;

  localparam int PHASE_W = 27;  // Q11.16 frame units, holds up to F * 65536
  localparam int DIV_W   = 27;  // dividend and quotient width of the divider
  localparam logic [16:0] PROG_ONE = 17'd65536;
  localparam logic [15:0] SPEED_RESET = 16'd256;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic mul1;
    logic mul2;
    logic mul3;
    logic sum;
    logic add;
    logic commit_work;
    logic hold_end;
    logic div_start;
    logic div_sel_work;
    logic apply_wrap;
    logic set_phase_p;
    logic follow;
    logic set_frame;
    logic pause;
    logic resume;
    logic reset_prog;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       anim;
    logic [2:0] op;
    logic       tick_blocked;
    logic       over_span;
    logic       loop_mode;
    logic       div_done;
    logic       prog_equal;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

### hdl/afs_div.sv
`default_nettype none
module afs_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [afs_pkg::DIV_W-1:0]  dividend,
  input  wire logic [10:0]                divisor,
  output logic      [afs_pkg::DIV_W-1:0]  quotient,
  output logic      [9:0]                 remainder,
  output logic                            done
);

  logic [4:0]  count;
  logic        busy;
  logic [10:0] rem_shift;
  logic        fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_shift = {remainder, quotient[afs_pkg::DIV_W-1]};
  assign fits = rem_shift >= divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && (count == 5'd1);
      if (start) begin
        busy  <= 1'b1;
        count <= 5'(afs_pkg::DIV_W);
      end else if (busy) begin
        count <= count - 5'd1;
        if (count == 5'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= {quotient[afs_pkg::DIV_W-2:0], fits};
      remainder <= fits ? 10'(rem_shift - divisor) : rem_shift[9:0];
    end
  end

endmodule
`default_nettype wire

### hdl/afs_datapath.sv
`default_nettype none
module afs_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic [2:0]         opcode,
  input  wire logic [23:0]        delta_time,
  input  wire logic [16:0]        progress_value,
  input  wire logic [9:0]         frame_value,
  input  wire afs_pkg::cmd_t      cmd,
  output afs_pkg::sts_t           sts,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output logic [9:0]              current_frame,
  output logic [15:0]             mix_factor,
  output logic [15:0]             loop_total,
  output logic                    completed,
  output logic                    is_paused,
  output logic [16:0]             progress_out,
  output logic                    frame_changed
);

  // Configuration
  logic [10:0] mesh_total;
  logic [9:0]  first_reg;
  logic [9:0]  last_reg;
  logic [15:0] fps;
  logic [15:0] speed;
  logic        loop_mode;

  // Playback state
  logic [afs_pkg::PHASE_W-1:0] phase;
  logic [9:0]  shown_frame;
  logic [15:0] blend;
  logic [15:0] cycle_count;
  logic        paused_flag;

  // Latched beat and work registers
  logic [2:0]  op;
  logic [23:0] dt;
  logic [16:0] pv;
  logic [9:0]  fv;
  logic [9:0]  frame_before;
  logic [39:0] prod;
  logic [35:0] part_lo;
  logic [35:0] part_hi;
  logic [39:0] inc;
  logic [40:0] work;

  // Clip range derived from the configuration
  logic [10:0] mesh_clamp;
  logic [10:0] mesh_last;
  logic [9:0]  clip_first;
  logic [9:0]  clip_last;
  logic [10:0] clip_count;
  logic [afs_pkg::PHASE_W-1:0] span;
  logic        anim;
  logic        done_now;

  always_comb begin
    if (mesh_total > afs_pkg::MAX_FRAMES) begin
      mesh_clamp = afs_pkg::MAX_FRAMES;
    end else begin
      mesh_clamp = mesh_total;
    end
    mesh_last = (mesh_clamp > 11'd1) ? mesh_clamp - 11'd1 : 11'd0;
    clip_first = ({1'b0, first_reg} < mesh_last) ? first_reg : mesh_last[9:0];
    if (last_reg < clip_first) begin
      clip_last = clip_first;
    end else if ({1'b0, last_reg} > mesh_last) begin
      clip_last = mesh_last[9:0];
    end else begin
      clip_last = last_reg;
    end
    clip_count = {1'b0, clip_last} - {1'b0, clip_first} + 11'd1;
    span = {clip_count, 16'd0};
  end

  assign anim = fps != 16'd0;
  assign done_now = anim && !loop_mode && (cycle_count != 16'd0);

  // Shared divider
  logic [afs_pkg::DIV_W-1:0] div_dividend;
  logic [afs_pkg::DIV_W-1:0] quotient;
  logic [9:0]  remainder;
  logic        div_done;

  assign div_dividend = cmd.div_sel_work ? afs_pkg::DIV_W'(work[40:16]) : phase;

  afs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (clip_count),
    .quotient  (quotient),
    .remainder (remainder),
    .done      (div_done)
  );

  logic [16:0] prog_clamp;
  logic [16:0] pv_clamp;
  logic [16:0] cycle_sum;
  logic [afs_pkg::DIV_W-1:0] wrap_sum;
  logic [11:0] follow_sum;
  logic [9:0]  follow_frame;
  logic [9:0]  target_frame;
  logic [27:0] prog_phase;

  always_comb begin
    prog_clamp = (quotient > afs_pkg::DIV_W'(afs_pkg::PROG_ONE)) ?
                 afs_pkg::PROG_ONE : quotient[16:0];
    pv_clamp = (pv > afs_pkg::PROG_ONE) ? afs_pkg::PROG_ONE : pv;
    cycle_sum = {1'b0, cycle_count} + 17'd1;
    wrap_sum = afs_pkg::DIV_W'(cycle_count) + quotient;
    follow_sum = {1'b0, phase[26:16]} + {2'd0, clip_first};
    follow_frame = (follow_sum > {2'd0, clip_last}) ? clip_last : follow_sum[9:0];
    if (fv < clip_first) begin
      target_frame = clip_first;
    end else if (fv > clip_last) begin
      target_frame = clip_last;
    end else begin
      target_frame = fv;
    end
    prog_phase = pv_clamp * clip_count;
  end

  // Status toward the controller
  always_comb begin
    sts.anim = anim;
    sts.op = op;
    sts.tick_blocked = done_now || paused_flag;
    sts.over_span = work >= 41'(span);
    sts.loop_mode = loop_mode;
    sts.div_done = div_done;
    sts.prog_equal = pv_clamp == prog_clamp;
    sts.out_free = !out_valid || !out_stall;
  end

  // Configuration writes and playback state
  always_ff @(posedge clk) begin
    if (rst) begin
      mesh_total  <= '0;
      first_reg   <= '0;
      last_reg    <= '0;
      fps         <= '0;
      speed       <= afs_pkg::SPEED_RESET;
      loop_mode   <= 1'b0;
      phase       <= '0;
      shown_frame <= '0;
      blend       <= '0;
      cycle_count <= '0;
      paused_flag <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          afs_pkg::REG_MESH_TOTAL: mesh_total <= cfg_data[10:0];
          afs_pkg::REG_FIRST:      first_reg  <= cfg_data[9:0];
          afs_pkg::REG_LAST:       last_reg   <= cfg_data[9:0];
          afs_pkg::REG_FPS:        fps        <= cfg_data;
          afs_pkg::REG_SPEED:      speed      <= cfg_data;
          afs_pkg::REG_LOOP: begin
            if (cfg_data[0] != loop_mode) begin
              cycle_count <= '0;
            end
            loop_mode <= cfg_data[0];
          end
          default: ;
        endcase
      end
      if (cmd.commit_work) begin
        phase <= work[afs_pkg::PHASE_W-1:0];
      end
      if (cmd.hold_end) begin
        phase <= span;
        cycle_count <= cycle_sum[16] ? 16'hFFFF : cycle_sum[15:0];
      end
      if (cmd.apply_wrap) begin
        phase <= {1'b0, remainder, work[15:0]};
        cycle_count <= (wrap_sum > afs_pkg::DIV_W'(16'hFFFF)) ? 16'hFFFF : wrap_sum[15:0];
      end
      if (cmd.set_phase_p) begin
        phase <= prog_phase[afs_pkg::PHASE_W-1:0];
      end
      if (cmd.follow) begin
        shown_frame <= follow_frame;
        blend <= phase[15:0];
      end
      if (cmd.set_frame) begin
        shown_frame <= target_frame;
        blend <= '0;
      end
      if (cmd.pause) begin
        paused_flag <= 1'b1;
      end
      if (cmd.resume) begin
        paused_flag <= 1'b0;
      end
      if (cmd.reset_prog && (phase != '0 || cycle_count != 16'd0)) begin
        cycle_count <= '0;
        shown_frame <= clip_first;
        blend <= '0;
        phase <= '0;
      end
    end
  end

  // Beat capture and tick arithmetic
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op <= opcode;
      dt <= delta_time;
      pv <= progress_value;
      fv <= frame_value;
      frame_before <= shown_frame;
    end
    if (cmd.mul1) begin
      prod <= dt * speed;
    end
    if (cmd.mul2) begin
      part_lo <= prod[19:0] * fps;
    end
    if (cmd.mul3) begin
      part_hi <= prod[39:20] * fps;
    end
    if (cmd.sum) begin
      inc <= 40'(({part_hi, 20'd0} + {20'd0, part_lo}) >> 16);
    end
    if (cmd.add) begin
      work <= {1'b0, inc} + 41'(phase);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      current_frame <= shown_frame;
      mix_factor    <= blend;
      loop_total    <= cycle_count;
      completed     <= done_now;
      is_paused     <= paused_flag;
      progress_out  <= anim ? prog_clamp : 17'd0;
      frame_changed <= shown_frame != frame_before;
    end
  end

endmodule
`default_nettype wire

### hdl/afs_ctrl.sv
`default_nettype none
module afs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire afs_pkg::sts_t sts,
  output afs_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_MUL1   = 4'd2;
  localparam logic [3:0] S_MUL2   = 4'd3;
  localparam logic [3:0] S_MUL3   = 4'd4;
  localparam logic [3:0] S_SUM    = 4'd5;
  localparam logic [3:0] S_ADD    = 4'd6;
  localparam logic [3:0] S_CHECK  = 4'd7;
  localparam logic [3:0] S_WDIV   = 4'd8;
  localparam logic [3:0] S_FOLLOW = 4'd9;
  localparam logic [3:0] S_CMP    = 4'd10;
  localparam logic [3:0] S_PDIV   = 4'd11;
  localparam logic [3:0] S_PWAIT  = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence one beat through decode, arithmetic, progress and output
  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_PDIV;
        if (sts.anim) begin
          case (sts.op)
            afs_pkg::OP_TICK: begin
              if (!sts.tick_blocked) begin
                state_next = S_MUL1;
              end
            end
            afs_pkg::OP_SET_PROG: begin
              cmd.div_start = 1'b1;
              state_next = S_CMP;
            end
            afs_pkg::OP_SET_FRAME: cmd.set_frame = 1'b1;
            afs_pkg::OP_PAUSE:     cmd.pause = 1'b1;
            afs_pkg::OP_RESUME:    cmd.resume = 1'b1;
            afs_pkg::OP_RESET:     cmd.reset_prog = 1'b1;
            default: ;
          endcase
        end
      end
      S_MUL1: begin
        cmd.mul1 = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2 = 1'b1;
        state_next = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3 = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!sts.over_span) begin
          cmd.commit_work = 1'b1;
          state_next = S_FOLLOW;
        end else if (sts.loop_mode) begin
          cmd.div_start = 1'b1;
          cmd.div_sel_work = 1'b1;
          state_next = S_WDIV;
        end else begin
          cmd.hold_end = 1'b1;
          state_next = S_FOLLOW;
        end
      end
      S_WDIV: begin
        if (sts.div_done) begin
          cmd.apply_wrap = 1'b1;
          state_next = S_FOLLOW;
        end
      end
      S_FOLLOW: begin
        cmd.follow = 1'b1;
        state_next = S_PDIV;
      end
      S_CMP: begin
        if (sts.div_done) begin
          if (sts.prog_equal) begin
            state_next = S_PDIV;
          end else begin
            cmd.set_phase_p = 1'b1;
            state_next = S_FOLLOW;
          end
        end
      end
      S_PDIV: begin
        cmd.div_start = 1'b1;
        state_next = S_PWAIT;
      end
      S_PWAIT: begin
        if (sts.div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### hdl/animation_frame_sequencer.sv
// Sprite animation playback clock.
// Input channel (in_valid / in_stall) carries one command beat: tick with
// delta_time, set progress, set frame, pause, resume or reset progress.
// Output channel (out_valid / out_stall) returns one result beat per input
// beat: frame, mix factor, loop count, flags and progress.
// The configuration port (cfg_we, cfg_index, cfg_data) writes the clip and
// rate registers; write it only while no beat is in flight.
// The 27-step divider runs once for progress on every beat and once more
// for a loop wrap or a progress compare. Pause, resume, set frame, reset
// progress, an unknown opcode or a blocked tick go straight to it; a tick
// first runs the multiplies, sum, add, span check and frame follow, and a
// set progress moves the phase and follows only if the compare differs.
// One beat is worked on at a time; in_stall is low only while the
// controller is idle, so the next beat is taken in the cycle after a
// result is loaded.
// A finished result waits in the output register while out_stall is high;
// the next beat may be accepted meanwhile but its result holds until the
// register is free.
// Reset clears the clip registers, sets speed to 1.0 and clears the phase,
// frame, loop count and pause flag; no output beat is pending after reset.
`default_nettype none
module animation_frame_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  opcode,
  input  wire logic [23:0] delta_time,
  input  wire logic [16:0] progress_value,
  input  wire logic [9:0]  frame_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [9:0]       current_frame,
  output logic [15:0]      mix_factor,
  output logic [15:0]      loop_total,
  output logic             completed,
  output logic             is_paused,
  output logic [16:0]      progress_out,
  output logic             frame_changed
);

  afs_pkg::cmd_t cmd;
  afs_pkg::sts_t sts;

  afs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  afs_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .opcode         (opcode),
    .delta_time     (delta_time),
    .progress_value (progress_value),
    .frame_value    (frame_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .current_frame  (current_frame),
    .mix_factor     (mix_factor),
    .loop_total     (loop_total),
    .completed      (completed),
    .is_paused      (is_paused),
    .progress_out   (progress_out),
    .frame_changed  (frame_changed)
  );

endmodule
`default_nettype wire

### hdl/afs_checker.sv
`default_nettype none
module afs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [9:0]  current_frame,
  input wire logic [15:0] loop_total,
  input wire logic        completed,
  input wire logic [16:0] progress_out
);

  // Hold a stalled result beat
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(current_frame) && $stable(loop_total))
    else $error("stalled result beat changed");

  // Block further input right after a beat is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat accepted while busy");

  // Completion implies at least one finished cycle
  assert property (@(posedge clk) disable iff (rst)
    out_valid && completed |-> loop_total != 16'd0)
    else $error("completed without a finished cycle");

  // Progress never exceeds 1.0
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> progress_out <= 17'd65536)
    else $error("progress above one");

endmodule

bind animation_frame_sequencer afs_checker u_afs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .current_frame (current_frame),
  .loop_total    (loop_total),
  .completed     (completed),
  .progress_out  (progress_out)
);
`default_nettype wire
